@@ sv/tlru_pkg.sv @@
// Shared types and constants for the LRU translation buffer.
`timescale 1ns / 1ps
`default_nettype none

package tlru_pkg;

   localparam int PAGE_W      = 32;
   localparam int FRAME_W     = 32;
   localparam int CNT_W       = 32;
   localparam int LIMIT_W     = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } eng_state_type;

   typedef struct packed {
      op_type               op;
      logic [PAGE_W-1:0]    page;
      logic [FRAME_W-1:0]   new_frame;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [FRAME_W-1:0]   frame;
      logic [CNT_W-1:0]     hit_total;
      logic [CNT_W-1:0]     miss_total;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

`default_nettype wire

@@ sv/tlru_lookup_insert.sv @@
// Top level of the fully associative LRU translation buffer.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake             Payload
//  req_      in         push / full           func, page, new_frame
//  rsp_      out        empty / pop           hit, frame, hit_total, miss_total
//  csr_      in         csr_valid / csr_ready entries_in_use limit
//
//  The engine takes each request through a compare state, then an update state.
//  The update state pushes the response; no new request is taken until it is done.
//  Synchronous reset; no clearing pass.
//  A full response queue holds the engine; requests still queue in front.

module tlb_lru_lookup_insert
   import tlru_pkg::*;
#(
   parameter int ENTRIES = 16
)
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   output logic                req_full,
   input  wire                 req_func,
   input  wire [PAGE_W-1:0]    req_page,
   input  wire [FRAME_W-1:0]   req_new_frame,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output logic                rsp_hit,
   output logic [FRAME_W-1:0]  rsp_frame,
   output logic [CNT_W-1:0]    rsp_hit_total,
   output logic [CNT_W-1:0]    rsp_miss_total,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire [LIMIT_W-1:0]   csr_data
);

   logic [LIMIT_W-1:0]     limit_ff, limit_in;
   q_stat_type             req_stat;
   q_stat_type             rsp_stat;
   req_type                req_head;
   rsp_type                rsp_head;
   rsp_type                eng_rsp;
   logic                   eng_pop;
   logic                   eng_push;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   tlru_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .func      (req_func),
      .page      (req_page),
      .new_frame (req_new_frame),
      .pop       (eng_pop),
      .stat      (req_stat),
      .head      (req_head)
   );

   tlru_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .req_head  (req_head),
      .req_stat  (req_stat),
      .req_pop   (eng_pop),
      .rsp_stat  (rsp_stat),
      .rsp_push  (eng_push),
      .rsp_data  (eng_rsp)
   );

   tlru_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (eng_push),
      .data  (eng_rsp),
      .pop   (rsp_pop),
      .stat  (rsp_stat),
      .head  (rsp_head)
   );

   assign req_full       = req_stat.full;
   assign rsp_empty      = rsp_stat.empty;
   assign rsp_hit        = rsp_head.hit;
   assign rsp_frame      = rsp_head.frame;
   assign rsp_hit_total  = rsp_head.hit_total;
   assign rsp_miss_total = rsp_head.miss_total;

endmodule

`default_nettype wire

@@ sv/tlru_front.sv @@
// Request front end: decode and queue incoming requests.
`timescale 1ns / 1ps
`default_nettype none

module tlru_front
   import tlru_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  wire                 func,
   input  wire [PAGE_W-1:0]    page,
   input  wire [FRAME_W-1:0]   new_frame,
   input  wire                 pop,
   output q_stat_type          stat,
   output req_type             head
);

   req_type                slot_ff [QDEPTH];
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;
   req_type                dec;

   always_comb begin
      dec.op        = op_type'(func);
      dec.page      = page;
      dec.new_frame = new_frame;
   end

   assign stat.empty = (cnt_ff == QCNT_W'(0));
   assign stat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

@@ sv/tlru_rsp_queue.sv @@
// Response queue between the lookup engine and the response port.
`timescale 1ns / 1ps
`default_nettype none

module tlru_rsp_queue
   import tlru_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  rsp_type             data,
   input  wire                 pop,
   output q_stat_type          stat,
   output rsp_type             head
);

   rsp_type                slot_ff [QDEPTH];
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign stat.empty = (cnt_ff == QCNT_W'(0));
   assign stat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data;
      end
   end

endmodule

`default_nettype wire

@@ sv/tlru_engine.sv @@
// Lookup engine: tag compare, recency update, replacement and counters.
`timescale 1ns / 1ps
`default_nettype none

module tlru_engine
   import tlru_pkg::*;
#(
   parameter int ENTRIES = 16
)
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire [LIMIT_W-1:0]   limit,
   input  req_type             req_head,
   input  q_stat_type          req_stat,
   output logic                req_pop,
   input  q_stat_type          rsp_stat,
   output logic                rsp_push,
   output rsp_type             rsp_data
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_W  = RANK_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int LIM_W  = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

   eng_state_type          state_ff, state_in;

   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [RANK_W-1:0]      rank_ff [ENTRIES];
   logic [RANK_W-1:0]      rank_in [ENTRIES];
   logic [PAGE_W-1:0]      page_ff [ENTRIES];
   logic [FRAME_W-1:0]     frame_mem [ENTRIES];
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [CNT_W-1:0]       hits_ff, hits_in;
   logic [CNT_W-1:0]       misses_ff, misses_in;

   req_type                cur_ff;
   logic                   hit_ff;
   logic [ENTRIES-1:0]     match_vec_ff;
   logic [RANK_W-1:0]      match_rank_ff;
   logic [ENTRIES-1:0]     victim_vec_ff;
   logic                   evict_ff;
   logic [IDX_W-1:0]       slot_idx_ff;
   logic [FRAME_W-1:0]     rd_frame_ff;

   logic                   take;
   logic                   found;
   logic [IDX_W-1:0]       match_idx;
   logic [ENTRIES-1:0]     match_vec;
   logic [LIM_W-1:0]       lim_eff;
   logic                   evict;
   logic [OCC_W-1:0]       occ_m1;
   logic [ENTRIES-1:0]     victim_vec;
   logic [IDX_W-1:0]       slot_idx;
   logic                   fill_we;

   assign take    = (state_ff == ST_IDLE) && !req_stat.empty && !rsp_stat.full;
   assign req_pop = take;

   // compare all entries against the head request; lowest index wins
   always_comb begin
      found     = 1'b0;
      match_idx = '0;
      match_vec = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == req_head.page)) begin
            found        = 1'b1;
            match_idx    = IDX_W'(i);
            match_vec    = '0;
            match_vec[i] = 1'b1;
         end
      end
   end

   always_comb begin
      lim_eff = LIM_W'(limit);
      if (lim_eff == LIM_W'(0)) begin
         lim_eff = LIM_W'(1);
      end else if (lim_eff > LIM_W'(ENTRIES)) begin
         lim_eff = LIM_W'(ENTRIES);
      end
   end

   assign evict  = (LIM_W'(occ_ff) >= lim_eff);
   assign occ_m1 = occ_ff - OCC_W'(1);

   // the least recent valid entry holds the highest rank, occupancy - 1
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim_vec[i] = evict && valid_ff[i] && (rank_ff[i] == RANK_W'(occ_m1));
      end
   end

   always_comb begin
      slot_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!(valid_ff[i] && !victim_vec[i])) begin
            slot_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      occ_in    = occ_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      rsp_push  = 1'b0;
      fill_we   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
            rsp_push = 1'b1;
            if (hit_ff) begin
               hits_in = hits_ff + CNT_W'(1);
               for (int i = 0; i < ENTRIES; i++) begin
                  if (match_vec_ff[i]) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && (rank_ff[i] < match_rank_ff)) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end
               end
            end else begin
               misses_in = misses_ff + CNT_W'(1);
               if (cur_ff.op == OP_INSERT) begin
                  fill_we = 1'b1;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (victim_vec_ff[i]) begin
                        valid_in[i] = 1'b0;
                        rank_in[i]  = '0;
                     end else if (valid_ff[i]) begin
                        rank_in[i] = rank_ff[i] + RANK_W'(1);
                     end
                  end
                  valid_in[slot_idx_ff] = 1'b1;
                  rank_in[slot_idx_ff]  = '0;
                  occ_in = evict_ff ? occ_ff : occ_ff + OCC_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data.hit        = hit_ff;
      rsp_data.frame      = hit_ff ? rd_frame_ff : '0;
      rsp_data.hit_total  = hits_in;
      rsp_data.miss_total = misses_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         occ_ff    <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         occ_ff    <= occ_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         rank_ff   <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff        <= req_head;
         hit_ff        <= found;
         match_vec_ff  <= match_vec;
         match_rank_ff <= rank_ff[match_idx];
         victim_vec_ff <= victim_vec;
         evict_ff      <= evict;
         slot_idx_ff   <= slot_idx;
      end
      if (fill_we) begin
         page_ff[slot_idx_ff] <= cur_ff.page;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         frame_mem[slot_idx_ff] <= cur_ff.new_frame;
      end
      if (take) begin
         rd_frame_ff <= frame_mem[match_idx];
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the LRU translation buffer: shadow model, drivers and checks.
`timescale 1ns / 1ps

module tb_top
   import tlru_pkg::*;
();

   localparam int TLB_DEPTH   = 16;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_REQS  = 190;
   localparam int POOL_SIZE   = 24;

   class tlb_mirror;
      logic                 valid [TLB_DEPTH];
      logic [PAGE_W-1:0]    vpage [TLB_DEPTH];
      logic [FRAME_W-1:0]   vframe [TLB_DEPTH];
      int unsigned          rank [TLB_DEPTH];
      int unsigned          occ;
      logic [CNT_W-1:0]     hits;
      logic [CNT_W-1:0]     misses;
      logic [LIMIT_W-1:0]   limit;
      rsp_type              expected_xlat [$];
      int unsigned          mismatches;
      int unsigned          n_requests;
      int unsigned          n_hits;
      int unsigned          n_evictions;
      int unsigned          n_limit_writes;

      function new();
         for (int i = 0; i < TLB_DEPTH; i++) begin
            valid[i] = 1'b0;
            rank[i]  = 0;
         end
         occ = 0;
         hits = '0;
         misses = '0;
         limit = LIMIT_RESET;
         mismatches = 0;
         n_requests = 0;
         n_hits = 0;
         n_evictions = 0;
         n_limit_writes = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = value;
         n_limit_writes++;
      endfunction

      function void evict_oldest();
         int victim;
         victim = -1;
         for (int i = 0; i < TLB_DEPTH; i++)
            if (valid[i] && (victim < 0 || rank[i] > rank[victim]))
               victim = i;
         if (victim >= 0) begin
            valid[victim] = 1'b0;
            rank[victim]  = 0;
            if (occ > 0)
               occ--;
            n_evictions++;
         end
      endfunction

      function int free_slot();
         for (int i = 0; i < TLB_DEPTH; i++)
            if (!valid[i])
               return i;
         return -1;
      endfunction

      function void take_request(op_type op, logic [PAGE_W-1:0] page,
                                 logic [FRAME_W-1:0] frame);
         int          found;
         int          slot;
         int unsigned cap;
         rsp_type     r;
         found = -1;
         r = '0;
         n_requests++;
         for (int i = 0; i < TLB_DEPTH; i++)
            if (valid[i] && vpage[i] == page) begin
               found = i;
               break;
            end
         if (found >= 0) begin
            r.hit   = 1'b1;
            r.frame = vframe[found];
            hits++;
            n_hits++;
            for (int j = 0; j < TLB_DEPTH; j++)
               if (valid[j] && rank[j] < rank[found])
                  rank[j]++;
            rank[found] = 0;
         end else begin
            misses++;
            if (op == OP_INSERT) begin
               cap = (limit == 0) ? 1 : (limit > TLB_DEPTH) ? TLB_DEPTH : limit;
               if (occ >= cap)
                  evict_oldest();
               slot = free_slot();
               if (slot < 0) begin
                  evict_oldest();
                  slot = free_slot();
               end
               if (slot >= 0) begin
                  for (int j = 0; j < TLB_DEPTH; j++)
                     if (valid[j])
                        rank[j]++;
                  valid[slot]  = 1'b1;
                  vpage[slot]  = page;
                  vframe[slot] = frame;
                  rank[slot]   = 0;
                  occ++;
               end
            end
         end
         r.hit_total  = hits;
         r.miss_total = misses;
         expected_xlat.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(logic hit, logic [FRAME_W-1:0] frame,
                                   logic [CNT_W-1:0] hit_total,
                                   logic [CNT_W-1:0] miss_total);
         rsp_type e;
         if (expected_xlat.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none, actual hit=%0b frame=%h",
                     $time, hit, frame);
            mismatches++;
            return;
         end
         e = expected_xlat.pop_front();
         compare_field("hit", {31'b0, e.hit}, {31'b0, hit});
         compare_field("frame", e.frame, frame);
         compare_field("hit_total", e.hit_total, hit_total);
         compare_field("miss_total", e.miss_total, miss_total);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic                req_func;
   logic [PAGE_W-1:0]   req_page;
   logic [FRAME_W-1:0]  req_new_frame;
   logic                rsp_empty;
   logic                rsp_pop;
   logic                rsp_hit;
   logic [FRAME_W-1:0]  rsp_frame;
   logic [CNT_W-1:0]    rsp_hit_total;
   logic [CNT_W-1:0]    rsp_miss_total;
   logic                csr_valid;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_data;

   tlb_mirror           sb = new();
   int unsigned         send_idle_pct;
   int unsigned         recv_idle_pct;
   int unsigned         stall_cycles;
   logic [PAGE_W-1:0]   page_pool [POOL_SIZE];
   logic [LIMIT_W-1:0]  phase_limit [9] = '{5'd31, 5'd1, 5'd0, 5'd7, 5'd16,
                                            5'd3, 5'd17, 5'd12, 5'd16};

   tlb_lru_lookup_insert #(.ENTRIES(TLB_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_page       (req_page),
      .req_new_frame  (req_new_frame),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hit        (rsp_hit),
      .rsp_frame      (rsp_frame),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_pop = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            sb.take_request(op_type'(req_func), req_page, req_new_frame);
         if (rsp_pop && !rsp_empty)
            sb.check_response(rsp_hit, rsp_frame, rsp_hit_total, rsp_miss_total);
         if (csr_valid && csr_ready)
            sb.set_limit(csr_data);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d requests outstanding",
                     $time, STALL_LIMIT, sb.expected_xlat.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // leaves push high at the falling edge after acceptance
   task automatic send_request(input op_type op, input logic [PAGE_W-1:0] page,
                               input logic [FRAME_W-1:0] frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         req_func = 1'($urandom_range(1));
         req_page = $urandom;
         @(negedge clock);
      end
      req_push      = 1'b1;
      req_func      = op;
      req_page      = page;
      req_new_frame = frame;
      do
         @(posedge clock);
      while (req_full);
      @(negedge clock);
   endtask

   task automatic drain();
      req_push = 1'b0;
      while (sb.expected_xlat.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain();
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_data  = LIMIT_W'($urandom);
   endtask

   task automatic send_random();
      op_type            op;
      logic [PAGE_W-1:0] page;
      int unsigned       pick;
      op   = ($urandom_range(99) < 45) ? OP_INSERT : OP_LOOKUP;
      pick = $urandom_range(99);
      if (pick < 84)
         page = page_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 92)
         page = page_pool[$urandom_range(POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(31));
      else
         page = $urandom;
      send_request(op, page, $urandom);
   endtask

   initial begin
      reset         = 1'b1;
      req_push      = 1'b0;
      req_func      = 1'b0;
      req_page      = '0;
      req_new_frame = '0;
      rsp_pop       = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_cycles  = 0;
      page_pool[0]  = 32'h0000_0000;
      page_pool[1]  = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         page_pool[i] = $urandom;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // empty table, extremes, hit on insert, fill to the limit and evict
      send_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
      for (int p = 1; p <= 14; p++)
         send_request(OP_INSERT, p, $urandom);
      send_request(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_LOOKUP, 32'hAAAA_AAAA, 32'h0);

      // lower the limit under the current occupancy
      write_limit(5'd2);
      send_request(OP_INSERT, 32'h0000_0100, $urandom);
      send_request(OP_INSERT, 32'h0000_0101, $urandom);
      send_request(OP_LOOKUP, 32'h0000_0100, $urandom);

      for (int ph = 0; ph < 9; ph++) begin
         write_limit(phase_limit[ph]);
         send_idle_pct = (ph < 3) ? 22 : (ph < 6) ? 56 : 0;
         recv_idle_pct = (ph < 3) ? 56 : (ph < 6) ? 22 : 0;
         for (int n = 0; n < PHASE_REQS; n++) begin
            if (n == PHASE_REQS / 2)
               drain();
            send_random();
         end
      end

      drain();
      repeat (10) @(negedge clock);
      $display("Run covered %0d requests: %0d hits, %0d evictions, %0d limit writes",
               sb.n_requests, sb.n_hits, sb.n_evictions, sb.n_limit_writes);
      $display("Limits 0, 1, 16 and 31 used, with idle sender, idle receiver and full rate");
      if (sb.mismatches == 0 && sb.expected_xlat.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
